[sv/lzwd_pkg.sv]
// Shared types, result kind codes and LZW constants for the variable-width decoder.
package lzwd_pkg;

    localparam int BYTE_W            = 8;
    localparam int LEN_W             = 12;
    localparam int KIND_W            = 3;
    localparam int WIDTH_W           = 4;
    localparam int DEF_MAX_CODE_BITS = 12;
    localparam int DEF_POSITION_BITS = 24;

    // Special codes and table layout
    localparam int ROOT_COUNT  = 256;
    localparam int CLEAR_CODE  = 256;
    localparam int END_CODE    = 257;
    localparam int FIRST_FREE  = 257;
    localparam int START_WIDTH = 9;

    // Two full-length strings fit below the top of the position range
    localparam int MARGIN_LOG = LEN_W + 1;

    typedef logic [KIND_W-1:0]  t_kind;
    typedef logic [WIDTH_W-1:0] t_cwidth;

    localparam t_kind KIND_LITERAL = 3'd0;
    localparam t_kind KIND_COPY    = 3'd1;
    localparam t_kind KIND_KWKW    = 3'd2;
    localparam t_kind KIND_CLEAR   = 3'd3;
    localparam t_kind KIND_END     = 3'd4;
    localparam t_kind KIND_ERROR   = 3'd5;

endpackage

[sv/lzwd_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module lzwd_ram #(
    parameter int WIDTH = lzwd_pkg::LEN_W,
    parameter int DEPTH = 1 << lzwd_pkg::DEF_MAX_CODE_BITS
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

[sv/lzwd_gather.sv]
// Bit gatherer: packs LSB-first bytes and cuts codes of the current width.
module lzwd_gather #(
    parameter int MAX_CODE_BITS = lzwd_pkg::DEF_MAX_CODE_BITS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_take,
    input  logic [lzwd_pkg::BYTE_W-1:0]      i_data_byte,
    input  lzwd_pkg::t_cwidth                i_code_width,
    output logic                             o_code_valid,
    output logic [MAX_CODE_BITS-1:0]         o_code
);
    import lzwd_pkg::*;

    localparam int CW    = MAX_CODE_BITS;
    localparam int BUF_W = MAX_CODE_BITS + BYTE_W;
    localparam int CNT_W = $clog2(BUF_W + 1);

    logic [BUF_W-1:0] r_buf, n_buf;
    logic [CNT_W-1:0] r_count, n_count;
    logic [BUF_W-1:0] merged;
    logic [CNT_W-1:0] filled;
    logic [CNT_W-1:0] width_x;
    logic [CW-1:0]    mask;

    always_comb begin
        merged       = r_buf | (BUF_W'(i_data_byte) << r_count);
        filled       = r_count + CNT_W'(BYTE_W);
        width_x      = CNT_W'(i_code_width);
        mask         = ~({CW{1'b1}} << i_code_width);
        o_code_valid = (filled >= width_x);
        o_code       = merged[CW-1:0] & mask;
        if (o_code_valid) begin
            n_buf   = merged >> i_code_width;
            n_count = filled - width_x;
        end else begin
            n_buf   = merged;
            n_count = filled;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buf   <= '0;
            r_count <= '0;
        end else if (i_take) begin
            r_buf   <= n_buf;
            r_count <= n_count;
        end
    end

    // Leftover bits always stay below one full code
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count < CNT_W'(MAX_CODE_BITS))
        else $error("bit gatherer holds a full code after a byte");

endmodule

[sv/lzw_variable_width_decoder_core.sv]
// Top level of the LZW variable-width decoder: code classing, table access, copy commands.
//
// Input channel: one packed byte per item (i_valid / o_ready), codes LSB first,
// 9 bits wide after reset or clear, growing to MAX_CODE_BITS as the table fills.
// Output channel: one copy command per decoded code (o_valid / i_ready): literal,
// copy from earlier output, copy then first byte, clear, end, or error. Bytes that
// complete no code, and codes after an end other than a clear, give no item.
// Throughput: one byte per cycle while o_ready is high. A byte is classed in its
// accept cycle and the table entry for its code is read from the string table RAM
// (one read, one write per cycle); the command passes the decode stage and then
// leaves through an output register. A write and a read of the same entry in one
// cycle are bypassed. Within 8192 positions of the top of the position range a
// code that writes bytes is settled only once its length is known, so o_ready
// stays low while each such code waits in the decode stage.
// Reset clears the bit buffer, the width (9), the next index (257) and all
// positions; the table RAM is not cleared and needs no clearing pass.
// When the receiver stalls, the output register and the decode stage hold and
// o_ready falls once both are full; nothing is dropped.
module lzw_variable_width_decoder_core #(
    parameter int MAX_CODE_BITS = lzwd_pkg::DEF_MAX_CODE_BITS,
    parameter int POSITION_BITS = lzwd_pkg::DEF_POSITION_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [lzwd_pkg::BYTE_W-1:0]   i_data_byte,
    output logic                          o_valid,
    input  logic                          i_ready,
    output lzwd_pkg::t_kind               o_kind,
    output logic [lzwd_pkg::BYTE_W-1:0]   o_literal_byte,
    output logic [POSITION_BITS-1:0]      o_source_position,
    output logic [lzwd_pkg::LEN_W-1:0]    o_copy_length,
    output logic [POSITION_BITS-1:0]      o_write_position
);
    import lzwd_pkg::*;

    localparam int CW    = MAX_CODE_BITS;
    localparam int NI_W  = MAX_CODE_BITS + 1;
    localparam int DEPTH = 1 << MAX_CODE_BITS;
    localparam int ENT_W = POSITION_BITS + LEN_W;
    localparam int TOT_W = LEN_W + 1;
    localparam int SUM_W = POSITION_BITS + 1;

    localparam logic [NI_W-1:0] TABLE_LIMIT = NI_W'(DEPTH);
    localparam logic [NI_W-1:0] NI_RESET    = NI_W'(FIRST_FREE);
    localparam logic [CW-1:0]   CODE_CLEAR  = CW'(CLEAR_CODE);
    localparam logic [CW-1:0]   CODE_END    = CW'(END_CODE);
    localparam logic [CW-1:0]   CODE_ROOTS  = CW'(ROOT_COUNT);
    localparam t_cwidth         WIDTH_RESET = WIDTH_W'(START_WIDTH);
    localparam t_cwidth         WIDTH_MAX   = WIDTH_W'(MAX_CODE_BITS);

    // ---------------------------------------------------------------
    // Control state: width, next free index, clear and end flags
    // ---------------------------------------------------------------
    t_cwidth           r_width, n_width;
    logic [NI_W-1:0]   r_ni, n_ni;
    logic              r_first, n_first;
    logic              r_stopped, n_stopped;

    // Datapath state, committed in the decode stage
    logic [POSITION_BITS-1:0] r_wp, r_prev_start;
    logic [LEN_W-1:0]         r_prev_len;

    // Decode stage (memory data arrives here)
    logic                     r_b_valid;
    t_kind                    r_b_kind;
    logic [BYTE_W-1:0]        r_b_lit;
    logic                     r_b_defer;
    logic                     r_b_wr_en;
    logic [CW-1:0]            r_b_wr_idx;
    logic                     r_b_byp_hit;
    logic [ENT_W-1:0]         r_b_byp_data;

    // Output register
    logic                     r_o_valid;
    t_kind                    r_o_kind;
    logic [BYTE_W-1:0]        r_o_lit;
    logic [POSITION_BITS-1:0] r_o_src;
    logic [LEN_W-1:0]         r_o_len;
    logic [POSITION_BITS-1:0] r_o_wpos;

    // ---------------------------------------------------------------
    // Bit gathering
    // ---------------------------------------------------------------
    logic          a_take;
    logic          g_code_valid;
    logic [CW-1:0] g_code;

    lzwd_gather #(
        .MAX_CODE_BITS(MAX_CODE_BITS)
    ) u_gather (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_take       (a_take),
        .i_data_byte  (i_data_byte),
        .i_code_width (r_width),
        .o_code_valid (g_code_valid),
        .o_code       (g_code)
    );

    // ---------------------------------------------------------------
    // Near the top of the position range: settle string codes late
    // ---------------------------------------------------------------
    logic danger;
    generate
        if (POSITION_BITS <= MARGIN_LOG) begin : g_short_pos
            assign danger = 1'b1;
        end else begin : g_long_pos
            assign danger = &r_wp[POSITION_BITS-1:MARGIN_LOG];
        end
    endgenerate

    // ---------------------------------------------------------------
    // Classify the code completed by this byte
    // ---------------------------------------------------------------
    logic            b_go;
    logic            a_enter;
    t_kind           a_kind;
    logic            a_data;
    logic            a_defer;
    logic            a_clear;
    logic            a_end;
    logic [NI_W-1:0] code_x;

    always_comb begin
        code_x  = NI_W'(g_code);
        a_enter = 1'b0;
        a_kind  = KIND_ERROR;
        a_clear = 1'b0;
        a_end   = 1'b0;
        if (g_code_valid) begin
            if (g_code == CODE_CLEAR) begin
                a_enter = 1'b1;
                a_kind  = KIND_CLEAR;
                a_clear = 1'b1;
            end else if (r_stopped) begin
                a_enter = 1'b0;
            end else if (g_code == CODE_END) begin
                a_enter = 1'b1;
                a_kind  = KIND_END;
                a_end   = 1'b1;
            end else if (r_first) begin
                a_enter = 1'b1;
                a_kind  = (g_code < CODE_ROOTS) ? KIND_LITERAL : KIND_ERROR;
            end else if (g_code < CODE_ROOTS) begin
                a_enter = 1'b1;
                a_kind  = KIND_LITERAL;
            end else if (code_x < r_ni) begin
                a_enter = 1'b1;
                a_kind  = KIND_COPY;
            end else if (code_x == r_ni) begin
                a_enter = 1'b1;
                a_kind  = KIND_KWKW;
            end else begin
                a_enter = 1'b1;
                a_kind  = KIND_ERROR;
            end
        end
        a_data  = a_enter && (a_kind == KIND_LITERAL || a_kind == KIND_COPY ||
                              a_kind == KIND_KWKW);
        a_defer = a_data && danger;
    end

    // Hold off new bytes while the decode stage is full and stuck, or while a
    // late-settled code still owns the control state.
    assign o_ready = (!r_b_valid || b_go) && !(r_b_valid && r_b_defer);
    assign a_take  = i_valid && o_ready;

    // ---------------------------------------------------------------
    // Table advance for one accepted string code
    // ---------------------------------------------------------------
    logic [NI_W-1:0] adv_ni;
    t_cwidth         adv_width;
    logic            adv_wr_en;

    always_comb begin
        adv_ni    = (r_ni < TABLE_LIMIT) ? r_ni + NI_W'(1) : r_ni;
        adv_width = (((adv_ni >> r_width) != '0) && (r_width < WIDTH_MAX)) ?
                    r_width + WIDTH_W'(1) : r_width;
        adv_wr_en = !r_first && (r_ni < TABLE_LIMIT);
    end

    // ---------------------------------------------------------------
    // Decode stage: positions, lengths, overflow check, table write
    // ---------------------------------------------------------------
    logic [ENT_W-1:0]         ram_rdata;
    logic [ENT_W-1:0]         mem_entry;
    logic [POSITION_BITS-1:0] mem_start;
    logic [LEN_W-1:0]         mem_len;
    logic                     b_data;
    logic [TOT_W-1:0]         b_total;
    logic [POSITION_BITS-1:0] b_src;
    logic [LEN_W-1:0]         b_len;
    logic [SUM_W-1:0]         b_sum;
    logic                     b_ovf;
    logic                     b_err;
    logic                     b_commit;
    t_kind                    b_out_kind;
    logic                     ram_we;
    logic [ENT_W-1:0]         ram_wdata;
    logic                     ram_re;

    always_comb begin
        mem_entry = r_b_byp_hit ? r_b_byp_data : ram_rdata;
        mem_start = mem_entry[ENT_W-1:LEN_W];
        mem_len   = mem_entry[LEN_W-1:0];
        b_data    = (r_b_kind == KIND_LITERAL || r_b_kind == KIND_COPY ||
                     r_b_kind == KIND_KWKW);
        case (r_b_kind)
            KIND_LITERAL: begin
                b_total = TOT_W'(1);
                b_src   = '0;
                b_len   = '0;
            end
            KIND_COPY: begin
                b_total = TOT_W'(mem_len);
                b_src   = mem_start;
                b_len   = mem_len;
            end
            KIND_KWKW: begin
                b_total = TOT_W'(r_prev_len) + TOT_W'(1);
                b_src   = r_prev_start;
                b_len   = r_prev_len;
            end
            default: begin
                b_total = '0;
                b_src   = '0;
                b_len   = '0;
            end
        endcase
        b_sum      = {1'b0, r_wp} + SUM_W'(b_total);
        b_ovf      = b_sum[POSITION_BITS];
        b_err      = r_b_defer && b_data && b_ovf;
        b_commit   = b_data && !b_err;
        b_out_kind = b_err ? KIND_ERROR : r_b_kind;
        ram_we     = b_go && r_b_wr_en && !b_err;
        ram_wdata  = {((r_b_kind == KIND_KWKW) ? r_wp : r_prev_start),
                      r_prev_len + LEN_W'(1)};
        ram_re     = a_take && g_code_valid;
    end

    assign b_go = r_b_valid && (!r_o_valid || i_ready);

    lzwd_ram #(
        .WIDTH(ENT_W),
        .DEPTH(DEPTH)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (ram_we),
        .i_wr_addr (r_b_wr_idx),
        .i_wr_data (ram_wdata),
        .i_rd_en   (ram_re),
        .i_rd_addr (g_code),
        .o_rd_data (ram_rdata)
    );

    // ---------------------------------------------------------------
    // Control state update: clear and end at accept, string codes at
    // accept or, when deferred, once the decode stage has settled them
    // ---------------------------------------------------------------
    always_comb begin
        n_width   = r_width;
        n_ni      = r_ni;
        n_first   = r_first;
        n_stopped = r_stopped;
        if (a_take && a_clear) begin
            n_width   = WIDTH_RESET;
            n_ni      = NI_RESET;
            n_first   = 1'b1;
            n_stopped = 1'b0;
        end else if (a_take && a_end) begin
            n_stopped = 1'b1;
        end else if ((a_take && a_data && !a_defer) ||
                     (b_go && r_b_defer && b_commit)) begin
            n_width = adv_width;
            n_ni    = adv_ni;
            n_first = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width   <= WIDTH_RESET;
            r_ni      <= NI_RESET;
            r_first   <= 1'b1;
            r_stopped <= 1'b0;
        end else begin
            r_width   <= n_width;
            r_ni      <= n_ni;
            r_first   <= n_first;
            r_stopped <= n_stopped;
        end
    end

    // Positions advance only when a command leaves the decode stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp         <= '0;
            r_prev_start <= '0;
            r_prev_len   <= '0;
        end else if (b_go) begin
            if (r_b_kind == KIND_CLEAR) begin
                r_wp         <= '0;
                r_prev_start <= '0;
                r_prev_len   <= '0;
            end else if (b_commit) begin
                r_wp         <= b_sum[POSITION_BITS-1:0];
                r_prev_start <= r_wp;
                r_prev_len   <= b_total[LEN_W-1:0];
            end
        end
    end

    // Decode stage registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (a_take && a_enter) begin
            r_b_valid <= 1'b1;
        end else if (b_go) begin
            r_b_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_take && a_enter) begin
            r_b_kind     <= a_kind;
            r_b_lit      <= g_code[BYTE_W-1:0];
            r_b_defer    <= a_defer;
            r_b_wr_en    <= a_data && adv_wr_en;
            r_b_wr_idx   <= r_ni[CW-1:0];
            // Catch a write to the entry being read in the same cycle
            r_b_byp_hit  <= ram_we && (r_b_wr_idx == g_code);
            r_b_byp_data <= ram_wdata;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (b_go) begin
            r_o_valid <= 1'b1;
        end else if (i_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_go) begin
            r_o_kind <= b_out_kind;
            r_o_lit  <= (b_commit && r_b_kind == KIND_LITERAL) ? r_b_lit : '0;
            r_o_src  <= b_commit ? b_src : '0;
            r_o_len  <= b_commit ? b_len : '0;
            r_o_wpos <= b_commit ? r_wp : '0;
        end
    end

    assign o_valid           = r_o_valid;
    assign o_kind            = r_o_kind;
    assign o_literal_byte    = r_o_lit;
    assign o_source_position = r_o_src;
    assign o_copy_length     = r_o_len;
    assign o_write_position  = r_o_wpos;

    // ---------------------------------------------------------------
    // Checks
    // ---------------------------------------------------------------
    a_defer_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_b_valid && r_b_defer |-> !o_ready)
        else $error("byte taken while a deferred code owns the control state");

    a_margin_safe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_b_valid && !r_b_defer && b_data |-> !b_ovf)
        else $error("early-settled code overflows the position range");

    a_width_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_width >= WIDTH_RESET) && (r_width <= WIDTH_MAX))
        else $error("code width out of range");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid && !i_ready |=> $stable(r_o_kind) && $stable(r_o_wpos))
        else $error("output command changed while stalled");

endmodule
